>>> rtl/pfd_pkg.sv
// Shared types, constants and the sequencer control store of the PPM frame decoder.
package pfd_pkg;

  localparam int unsigned CHANNELS_DEF = 7;
  localparam int unsigned REPORT_LIMIT = 7;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned CFG_IDX_W    = 8;

  localparam logic [TIME_W-1:0] SYNC_MIN_RST = 16'd2700;
  localparam logic [TIME_W-1:0] SYNC_MAX_RST = 16'd20000;
  localparam logic [TIME_W-1:0] DATA_MIN_RST = 16'd800;
  localparam logic [TIME_W-1:0] DATA_MAX_RST = 16'd2200;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX = 8'd3;

  typedef enum logic [2:0] {
    EV_SYNC_REJECT   = 3'd0,
    EV_FRAME_START   = 3'd1,
    EV_CH_STORED     = 3'd2,
    EV_CH_ERROR      = 3'd3,
    EV_CH_REPORT     = 3'd4,
    EV_START_REPORT  = 3'd5
  } event_t;

  typedef logic [1:0] step_t;
  localparam step_t STEP_CAPTURE = 2'd0;
  localparam step_t STEP_STATUS  = 2'd1;
  localparam step_t STEP_REPORT  = 2'd2;

  typedef enum logic {
    WAIT_IN  = 1'b0,
    WAIT_OUT = 1'b1
  } wait_t;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_STATUS  = 2'd1,
    OP_REPORT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_REPORT   = 2'd1,
    COND_REP_LAST = 2'd2
  } cond_t;

  typedef struct packed {
    wait_t wait_on;
    op_t   op;
    cond_t cond;
    step_t jump_to;
    step_t next_to;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    case (step)
      STEP_CAPTURE: c = '{WAIT_IN,  OP_CAPTURE, COND_NEVER,    STEP_CAPTURE, STEP_STATUS};
      STEP_STATUS:  c = '{WAIT_OUT, OP_STATUS,  COND_REPORT,   STEP_REPORT,  STEP_CAPTURE};
      STEP_REPORT:  c = '{WAIT_OUT, OP_REPORT,  COND_REP_LAST, STEP_CAPTURE, STEP_REPORT};
      default:      c = '{WAIT_IN,  OP_CAPTURE, COND_NEVER,    STEP_CAPTURE, STEP_CAPTURE};
    endcase
    return c;
  endfunction

endpackage

>>> rtl/pfd_in_if.sv
// Input channel carrying one edge capture time per item.
interface pfd_in_if;
  logic                            valid;
  logic                            ready;
  logic [pfd_pkg::TIME_W-1:0]      capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

>>> rtl/pfd_out_if.sv
// Result channel carrying decoder events and channel widths.
interface pfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      event_res;
  logic [3:0]                      channel_index;
  logic [pfd_pkg::TIME_W-1:0]      width;
  logic                            last;

  modport source (output valid, output event_res, output channel_index, output width,
                  output last, input ready);
  modport sink   (input valid, input event_res, input channel_index, input width,
                  input last, output ready);
endinterface

>>> rtl/pfd_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface pfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfd_pkg::CFG_IDX_W-1:0]   index;
  logic [pfd_pkg::TIME_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ppm_frame_decoder.sv
// PPM frame decoder top level with its microcoded sequencer and datapath.
//
// Each item is a timer value captured at a pulse edge; the block forms the interval since
// the previous edge and classifies it against the sync and data windows. A three-step
// control program runs the datapath: capture, status, and an optional report loop. An
// ordinary item passes through capture, then status into the output register. A sync
// that closes a complete frame then runs the report loop once per reported channel, for
// min(CHANNELS, 7) channels, since every result passes through the single output
// register. Stalls on the result channel hold the sequencer in its current step.
module ppm_frame_decoder #(
  parameter int unsigned CHANNELS = pfd_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pfd_in_if.sink        in_if,
  pfd_out_if.source     out_if,
  pfd_cfg_if.sink       cfg_if
);

  localparam int unsigned REPORTS = (CHANNELS < pfd_pkg::REPORT_LIMIT) ?
                                    CHANNELS : pfd_pkg::REPORT_LIMIT;
  localparam int unsigned IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TW      = pfd_pkg::TIME_W;
  localparam logic [pfd_pkg::POS_W-1:0] POS_WAIT = pfd_pkg::POS_W'(CHANNELS);
  localparam logic [IDX_W-1:0]          REP_END  = IDX_W'(REPORTS - 1);

  logic [TW-1:0]              sync_min_r;
  logic [TW-1:0]              sync_max_r;
  logic [TW-1:0]              data_min_r;
  logic [TW-1:0]              data_max_r;

  pfd_pkg::step_t             step_r;
  pfd_pkg::step_t             step_nxt;
  pfd_pkg::ctrl_t             ctrl;

  logic [TW-1:0]              last_edge_r;
  logic [TW-1:0]              gap_r;
  logic [pfd_pkg::POS_W-1:0]  pos_r;
  logic [pfd_pkg::POS_W-1:0]  pos_nxt;
  logic                       fv_r;
  logic                       fv_nxt;
  logic [IDX_W-1:0]           rep_cnt_r;
  logic [TW-1:0]              store_r [CHANNELS];

  logic                       out_valid_r;
  pfd_pkg::event_t            out_ev_r;
  logic [3:0]                 out_idx_r;
  logic [TW-1:0]              out_width_r;
  logic                       out_last_r;

  logic                       in_acc;
  logic                       out_free;
  logic                       fire;
  logic                       cond_true;
  logic                       waiting;
  logic                       sync_ok;
  logic                       data_ok;
  logic                       report_now;
  logic                       store_we;
  logic                       rep_last;
  pfd_pkg::event_t            st_ev;
  logic [3:0]                 st_idx;
  logic                       do_capture;
  logic                       do_status;
  logic                       do_report;

  assign ctrl     = pfd_pkg::ucode(step_r);
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign rep_last = (rep_cnt_r == REP_END);

  assign waiting = (pos_r >= POS_WAIT);
  assign sync_ok = (gap_r > sync_min_r) && (gap_r < sync_max_r);
  assign data_ok = (gap_r > data_min_r) && (gap_r < data_max_r);

  always_comb begin
    st_ev      = pfd_pkg::EV_SYNC_REJECT;
    st_idx     = 4'd0;
    pos_nxt    = pos_r;
    fv_nxt     = fv_r;
    store_we   = 1'b0;
    report_now = 1'b0;
    if (waiting) begin
      pos_nxt = POS_WAIT;
      if (!sync_ok) begin
        fv_nxt = 1'b0;
      end else if (!fv_r) begin
        st_ev   = pfd_pkg::EV_FRAME_START;
        pos_nxt = '0;
      end else begin
        st_ev      = pfd_pkg::EV_START_REPORT;
        pos_nxt    = '0;
        fv_nxt     = 1'b0;
        report_now = 1'b1;
      end
    end else if (data_ok) begin
      st_ev    = pfd_pkg::EV_CH_STORED;
      st_idx   = pos_r[3:0];
      store_we = 1'b1;
      pos_nxt  = pos_r + 1'b1;
      if (pos_nxt == POS_WAIT) begin
        fv_nxt = 1'b1;
      end
    end else begin
      st_ev   = pfd_pkg::EV_CH_ERROR;
      st_idx  = pos_r[3:0];
      pos_nxt = POS_WAIT;
      fv_nxt  = 1'b0;
    end
  end

  always_comb begin
    fire = (ctrl.wait_on == pfd_pkg::WAIT_IN) ? in_acc : out_free;
    case (ctrl.cond)
      pfd_pkg::COND_NEVER:    cond_true = 1'b0;
      pfd_pkg::COND_REPORT:   cond_true = report_now;
      pfd_pkg::COND_REP_LAST: cond_true = rep_last;
      default:                cond_true = 1'b0;
    endcase
    step_nxt = fire ? (cond_true ? ctrl.jump_to : ctrl.next_to) : step_r;
  end

  always_comb begin
    in_if.ready = (ctrl.wait_on == pfd_pkg::WAIT_IN);
    do_capture  = fire && (ctrl.op == pfd_pkg::OP_CAPTURE);
    do_status   = fire && (ctrl.op == pfd_pkg::OP_STATUS);
    do_report   = fire && (ctrl.op == pfd_pkg::OP_REPORT);
  end

  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.event_res    = out_ev_r;
  assign out_if.channel_index = out_idx_r;
  assign out_if.width        = out_width_r;
  assign out_if.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= pfd_pkg::STEP_CAPTURE;
      last_edge_r <= '0;
      pos_r       <= POS_WAIT;
      fv_r        <= 1'b0;
      rep_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      sync_min_r  <= pfd_pkg::SYNC_MIN_RST;
      sync_max_r  <= pfd_pkg::SYNC_MAX_RST;
      data_min_r  <= pfd_pkg::DATA_MIN_RST;
      data_max_r  <= pfd_pkg::DATA_MAX_RST;
    end else begin
      step_r <= step_nxt;
      if (do_capture) begin
        last_edge_r <= in_if.capture_time;
      end
      if (do_status) begin
        pos_r     <= pos_nxt;
        fv_r      <= fv_nxt;
        rep_cnt_r <= '0;
      end
      if (do_report) begin
        rep_cnt_r <= rep_cnt_r + 1'b1;
      end
      if (do_status || do_report) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          pfd_pkg::REG_SYNC_MIN: sync_min_r <= cfg_if.data;
          pfd_pkg::REG_SYNC_MAX: sync_max_r <= cfg_if.data;
          pfd_pkg::REG_DATA_MIN: data_min_r <= cfg_if.data;
          pfd_pkg::REG_DATA_MAX: data_max_r <= cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_capture) begin
      gap_r <= in_if.capture_time - last_edge_r;
    end
    if (do_status && store_we) begin
      store_r[pos_r[IDX_W-1:0]] <= gap_r;
    end
    if (do_status) begin
      out_ev_r    <= st_ev;
      out_idx_r   <= st_idx;
      out_width_r <= gap_r;
      out_last_r  <= !report_now;
    end else if (do_report) begin
      out_ev_r    <= pfd_pkg::EV_CH_REPORT;
      out_idx_r   <= 4'(rep_cnt_r);
      out_width_r <= store_r[rep_cnt_r];
      out_last_r  <= rep_last;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (step_r == pfd_pkg::STEP_STATUS))
    else $error("accepted item not followed by status step");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_WAIT)
    else $error("channel position beyond channel count");

  a_valid_frame_waits: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r |-> (pos_r == POS_WAIT))
    else $error("valid frame mark set outside sync wait");

  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (do_report && rep_last) |=> (step_r == pfd_pkg::STEP_CAPTURE) && out_last_r)
    else $error("report sequence did not end on last item");

  a_report_index: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == pfd_pkg::STEP_REPORT) |-> (rep_cnt_r <= REP_END))
    else $error("report counter past report count");
`endif

endmodule
